// ===== src/glsu_pkg.sv =====
// Package for the gradient line stepper: widths, codes and the command and
// status structs passed between controller and datapath.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package glsu_pkg;

    localparam int COORD_BITS = 10;
    localparam int RAMP_BITS  = 12;
    localparam int STEP_BITS  = RAMP_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int REM_BITS   = COORD_BITS + 1;
    localparam int LEVEL_BITS = 4;
    localparam int LEVEL_LSB  = 8;
    localparam int DIV_STEPS  = RAMP_BITS;
    localparam int CNT_BITS   = $clog2(DIV_STEPS);

    localparam logic [RAMP_BITS-1:0] RAMP_FULL = RAMP_BITS'(14 << 8);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [LEVEL_BITS-1:0] level_t;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // latch a new line and seed the divider
        logic div_shift;   // one restoring-division step
        logic div_finish;  // final division step, write the ramp increment
        logic emit;        // capture the current pixel into the output register
        logic advance;     // walk to the next pixel
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic zero_len;    // requested line has equal endpoints
        logic last;        // current pixel is the final one
    } dp_status_t;

endpackage

`default_nettype wire

// ===== src/glsu_if.sv =====
// Handshake channels of the gradient line stepper: line requests in,
// pixels out. Depends on glsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface glsu_line_if;
    logic             valid;
    logic             ready;
    glsu_pkg::op_t    opcode;
    glsu_pkg::coord_t start_x;
    glsu_pkg::coord_t start_y;
    glsu_pkg::coord_t end_x;
    glsu_pkg::coord_t end_y;
    logic             reversed;

    modport source (output valid, opcode, start_x, start_y, end_x, end_y, reversed,
                    input ready);
    modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, reversed,
                    output ready);
endinterface

interface glsu_pixel_if;
    logic             valid;
    logic             ready;
    glsu_pkg::coord_t pixel_x;
    glsu_pkg::coord_t pixel_y;
    glsu_pkg::level_t level;
    logic             last;

    modport source (output valid, pixel_x, pixel_y, level, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, level, last, output ready);
endinterface

`default_nettype wire

// ===== src/glsu_ctrl.sv =====
// Controller of the gradient line stepper: request handshake, divider
// sequencing, line-active flag and output valid. Depends on glsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module glsu_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  glsu_pkg::op_t        in_opcode,
    output logic                 out_valid,
    input  wire                  out_ready,
    input  glsu_pkg::dp_status_t status,
    output glsu_pkg::dp_cmd_t    cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_DIV
    } state_t;

    state_t                        state_reg, state_next;
    logic [glsu_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                          active_reg, active_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          accept;
    logic                          is_load;
    logic                          is_step;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign is_load   = accept && (in_opcode == glsu_pkg::OP_LOAD) && !status.zero_len;
    // a step with no line in flight is taken and dropped
    assign is_step   = accept && (in_opcode == glsu_pkg::OP_STEP) && active_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load       = is_load;
        cmd.div_shift  = (state_reg == S_DIV);
        cmd.div_finish = (state_reg == S_DIV) && (cnt_reg == '0);
        cmd.emit       = is_step;
        cmd.advance    = is_step && !status.last;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg;

        if (is_step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (is_load)
        begin
            active_next = 1'b1;
        end
        else if (is_step && status.last)
        begin
            active_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (is_load)
                begin
                    state_next = S_DIV;
                    cnt_next   = glsu_pkg::CNT_BITS'(glsu_pkg::DIV_STEPS - 1);
                end
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_DIV) && active_reg)
        else $error("load did not start the divider");

    a_finish_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_finish |=> (state_reg == S_IDLE))
        else $error("divider did not hand back to idle");

    a_last_clears_active: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !cmd.advance) |=> !active_reg && out_valid_reg)
        else $error("final pixel left the line active");
`endif

endmodule

`default_nettype wire

// ===== src/glsu_dpath.sv =====
// Datapath of the gradient line stepper: line geometry, restoring divider
// for the ramp increment, error-term walk and pixel output register.
// Depends on glsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module glsu_dpath (
    input  wire                   clk,
    input  wire                   rst_n,
    input  glsu_pkg::dp_cmd_t     cmd,
    output glsu_pkg::dp_status_t  status,
    input  glsu_pkg::coord_t      start_x,
    input  glsu_pkg::coord_t      start_y,
    input  glsu_pkg::coord_t      end_x,
    input  glsu_pkg::coord_t      end_y,
    input  wire                   reversed,
    output glsu_pkg::coord_t      pixel_x,
    output glsu_pkg::coord_t      pixel_y,
    output glsu_pkg::level_t      level,
    output logic                  last
);

    localparam int CB = glsu_pkg::COORD_BITS;
    localparam int EB = glsu_pkg::ERR_BITS;
    localparam int RB = glsu_pkg::RAMP_BITS;
    localparam int SB = glsu_pkg::STEP_BITS;

    glsu_pkg::coord_t              cur_x_reg, cur_y_reg;
    glsu_pkg::coord_t              major_reg, minor_reg;
    logic [glsu_pkg::REM_BITS-1:0] remaining_reg;
    logic signed [EB-1:0]          err_reg;
    logic [RB-1:0]                 ramp_reg;
    logic signed [SB-1:0]          ramp_step_reg;
    logic                          x_major_reg, x_neg_reg, y_neg_reg, rev_reg;
    logic [RB-1:0]                 quot_reg;
    glsu_pkg::coord_t              rem_reg;

    glsu_pkg::coord_t              px_reg, py_reg;
    glsu_pkg::level_t              level_reg;
    logic                          last_reg;

    // load geometry
    logic                          in_x_neg, in_y_neg, in_x_major;
    glsu_pkg::coord_t              dx, dy;

    // divider step
    logic [CB:0]                   trial;
    logic                          fits;
    glsu_pkg::coord_t              rem_next;
    logic [RB-1:0]                 quot_next;
    logic signed [SB-1:0]          step_mag;

    // walk
    logic signed [EB-1:0]          err_sum, major_ext;
    logic                          minor_move;
    glsu_pkg::coord_t              x_step, y_step;

    assign in_x_neg   = end_x < start_x;
    assign in_y_neg   = end_y < start_y;
    assign dx         = in_x_neg ? start_x - end_x : end_x - start_x;
    assign dy         = in_y_neg ? start_y - end_y : end_y - start_y;
    assign in_x_major = dx > dy;

    assign status.zero_len = (start_x == end_x) && (start_y == end_y);
    assign status.last     = (remaining_reg == '0);

    // shift the next dividend bit into the partial remainder
    assign trial     = {rem_reg, quot_reg[RB-1]};
    assign fits      = trial >= {1'b0, major_reg};
    assign rem_next  = fits ? CB'(trial - {1'b0, major_reg}) : trial[CB-1:0];
    assign quot_next = {quot_reg[RB-2:0], fits};
    assign step_mag  = {1'b0, quot_next};

    assign major_ext  = {{(EB-CB){1'b0}}, major_reg};
    assign err_sum    = err_reg + {{(EB-CB){1'b0}}, minor_reg};
    assign minor_move = x_major_reg ? (err_sum >= major_ext)
                                    : (!err_sum[EB-1] && (err_sum != '0));
    assign x_step     = x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
    assign y_step     = y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
            remaining_reg <= '0;
            err_reg       <= '0;
            ramp_reg      <= '0;
            ramp_step_reg <= '0;
            x_major_reg   <= 1'b0;
            x_neg_reg     <= 1'b0;
            y_neg_reg     <= 1'b0;
            rev_reg       <= 1'b0;
            quot_reg      <= '0;
            rem_reg       <= '0;
        end
        else if (cmd.load)
        begin
            cur_x_reg     <= start_x;
            cur_y_reg     <= start_y;
            major_reg     <= in_x_major ? dx : dy;
            minor_reg     <= in_x_major ? dy : dx;
            remaining_reg <= {1'b0, (in_x_major ? dx : dy)};
            err_reg       <= '0;
            ramp_reg      <= reversed ? '0 : glsu_pkg::RAMP_FULL;
            x_major_reg   <= in_x_major;
            x_neg_reg     <= in_x_neg;
            y_neg_reg     <= in_y_neg;
            rev_reg       <= reversed;
            quot_reg      <= glsu_pkg::RAMP_FULL;
            rem_reg       <= '0;
        end
        else
        begin
            if (cmd.div_shift)
            begin
                quot_reg <= quot_next;
                rem_reg  <= rem_next;
            end
            if (cmd.div_finish)
            begin
                ramp_step_reg <= rev_reg ? step_mag : -step_mag;
            end
            if (cmd.advance)
            begin
                ramp_reg      <= ramp_reg + ramp_step_reg[RB-1:0];
                remaining_reg <= remaining_reg - 1'b1;
                err_reg       <= minor_move ? err_sum - major_ext : err_sum;
                if (x_major_reg)
                begin
                    cur_x_reg <= x_step;
                    if (minor_move)
                    begin
                        cur_y_reg <= y_step;
                    end
                end
                else
                begin
                    cur_y_reg <= y_step;
                    if (minor_move)
                    begin
                        cur_x_reg <= x_step;
                    end
                end
            end
        end
    end

    // output register: hold until the next pixel is captured
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            px_reg    <= cur_x_reg;
            py_reg    <= cur_y_reg;
            level_reg <= ramp_reg[glsu_pkg::LEVEL_LSB +: glsu_pkg::LEVEL_BITS];
            last_reg  <= status.last;
        end
    end

    assign pixel_x = px_reg;
    assign pixel_y = py_reg;
    assign level   = level_reg;
    assign last    = last_reg;

`ifndef NO_ASSERTIONS
    a_load_clears_err: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (err_reg == '0) && (major_reg != '0))
        else $error("load left a stale error term or empty major axis");

    a_rising_step_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_finish && rev_reg) |=> !ramp_step_reg[SB-1])
        else $error("rising ramp got a negative increment");

    a_xmajor_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.advance && x_major_reg && !err_reg[EB-1] && (err_reg < major_ext))
        |=> !err_reg[EB-1] && (err_reg < major_ext))
        else $error("x-major error term left its range");
`endif

endmodule

`default_nettype wire

// ===== src/gradient_line_stepper_unit.sv =====
// Top level of the gradient line stepper: Bresenham walk with a 4-bit level
// ramp. Depends on glsu_pkg, glsu_if, glsu_ctrl and glsu_dpath.
//
//   channel    | dir | handshake   | payload
//   line_in    | in  | valid/ready | opcode, start_x, start_y, end_x, end_y, reversed
//   pixel_out  | out | valid/ready | pixel_x, pixel_y, level, last
//
// A step's pixel is registered and offered in the next cycle; pixels stream at
// one per cycle while the sink keeps ready high. A line load is accepted, then
// the bit-serial restoring divider forms the ramp increment; no request is taken
// until it ends. Zero-length loads and steps with no line in flight give no pixel.
// Reset is asynchronous, active low, and leaves the block idle with no line.
// A stalled pixel is held in the output register; a further request waits on it.
`timescale 1ns / 1ps
`default_nettype none

module gradient_line_stepper_unit (
    input  wire          clk,
    input  wire          rst_n,
    glsu_line_if.sink    line_in,
    glsu_pixel_if.source pixel_out
);

    glsu_pkg::dp_cmd_t    cmd;
    glsu_pkg::dp_status_t status;

    glsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (line_in.valid),
        .in_ready  (line_in.ready),
        .in_opcode (line_in.opcode),
        .out_valid (pixel_out.valid),
        .out_ready (pixel_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    glsu_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .start_x  (line_in.start_x),
        .start_y  (line_in.start_y),
        .end_x    (line_in.end_x),
        .end_y    (line_in.end_y),
        .reversed (line_in.reversed),
        .pixel_x  (pixel_out.pixel_x),
        .pixel_y  (pixel_out.pixel_y),
        .level    (pixel_out.level),
        .last     (pixel_out.last)
    );

endmodule

`default_nettype wire
